// ----- sv/tsfg_pkg.sv -----
// ----------------------------------------------------------------------------
// TCP SYN frame generator package
// Shared widths, header constants, register indexes and interface structs.
// ----------------------------------------------------------------------------
package tsfg_pkg;

  localparam int PORT_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 6;
  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int PDATA_W = 64;
  localparam int PADDR_W = 5;

  localparam logic [IDX_W-1:0] LAST_IDX = 6'd57;

  localparam logic [1:0] REG_SRC_MAC = 2'd0;
  localparam logic [1:0] REG_DST_MAC = 2'd1;
  localparam logic [1:0] REG_SRC_IP  = 2'd2;
  localparam logic [1:0] REG_DST_IP  = 2'd3;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [15:0] IP_TOTAL_LEN  = 16'h002C;
  localparam logic [15:0] IP_ID         = 16'h568E;
  localparam logic [7:0]  IP_TTL        = 8'h32;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'h06;
  localparam logic [15:0] TCP_SRC_PORT  = 16'hD55E;
  localparam logic [7:0]  TCP_DATA_OFF  = 8'h60;
  localparam logic [7:0]  TCP_FLAG_SYN  = 8'h02;
  localparam logic [15:0] TCP_WINDOW    = 16'h0400;
  localparam logic [7:0]  OPT_KIND_MSS  = 8'h02;
  localparam logic [7:0]  OPT_LEN_MSS   = 8'h04;
  localparam logic [15:0] OPT_MSS       = 16'h05B4;
  localparam logic [15:0] TCP_SEG_LEN   = 16'h0018;

  // Sums of the fixed header words, address words and port excluded.
  localparam logic [18:0] IP_CONST_SUM =
    19'({3'b0, IP_VER_IHL, 8'h00} + {3'b0, IP_TOTAL_LEN} + {3'b0, IP_ID}
        + {3'b0, IP_TTL, IP_PROTO_TCP});
  localparam logic [18:0] TCP_CONST_SUM =
    19'({11'b0, IP_PROTO_TCP} + {3'b0, TCP_SEG_LEN} + {3'b0, TCP_SRC_PORT}
        + {3'b0, TCP_DATA_OFF, TCP_FLAG_SYN} + {3'b0, TCP_WINDOW}
        + {3'b0, OPT_KIND_MSS, OPT_LEN_MSS} + {3'b0, OPT_MSS});

  typedef struct packed {
    logic [MAC_W-1:0] src_mac;
    logic [MAC_W-1:0] dst_mac;
    logic [IP_W-1:0]  src_ip;
    logic [IP_W-1:0]  dst_ip;
  } cfg_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [15:0]       ip_cksum;
    logic [15:0]       tcp_cksum;
  } hdr_t;

endpackage

// ----- sv/tsfg_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one TCP destination port per item.
// ----------------------------------------------------------------------------
interface tsfg_req_if
  import tsfg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] target_port;

  modport source (output valid, output target_port, input ready);
  modport sink (input valid, input target_port, output ready);
endinterface

// ----- sv/tsfg_frame_if.sv -----
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel carrying one frame byte with its offset per item.
// ----------------------------------------------------------------------------
interface tsfg_frame_if
  import tsfg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [IDX_W-1:0]  byte_index;
  logic              last_byte;

  modport source (output valid, output frame_byte, output byte_index,
                  output last_byte, input ready);
  modport sink (input valid, input frame_byte, input byte_index,
                input last_byte, output ready);
endinterface

// ----- sv/tsfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the MAC and IPv4 addresses.
// ----------------------------------------------------------------------------
module tsfg_regs
  import tsfg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SRC_MAC: cfg.src_mac <= pwdata[MAC_W-1:0];
        REG_DST_MAC: cfg.dst_mac <= pwdata[MAC_W-1:0];
        REG_SRC_IP:  cfg.src_ip  <= pwdata[IP_W-1:0];
        REG_DST_IP:  cfg.dst_ip  <= pwdata[IP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_MAC: prdata = {{(PDATA_W-MAC_W){1'b0}}, cfg.src_mac};
      REG_DST_MAC: prdata = {{(PDATA_W-MAC_W){1'b0}}, cfg.dst_mac};
      REG_SRC_IP:  prdata = {{(PDATA_W-IP_W){1'b0}}, cfg.src_ip};
      REG_DST_IP:  prdata = {{(PDATA_W-IP_W){1'b0}}, cfg.dst_ip};
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- sv/tsfg_cksum.sv -----
// ----------------------------------------------------------------------------
// Checksum pipeline
// Three-stage pipeline forming the IPv4 header and TCP checksums of a request.
// ----------------------------------------------------------------------------
module tsfg_cksum
  import tsfg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PORT_W-1:0] in_port,
  output logic              out_valid,
  input  logic              out_ready,
  output hdr_t              out_hdr
);

  logic              v1, v2, v3;
  logic              rdy1, rdy2, rdy3;
  logic [PORT_W-1:0] port1, port2;
  logic [18:0]       ip_sum1, tcp_sum1;
  logic [16:0]       ip_sum2, tcp_sum2;
  logic [17:0]       addr_sum;
  logic [15:0]       ip_fold, tcp_fold;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign addr_sum = {2'b0, cfg.src_ip[31:16]} + {2'b0, cfg.src_ip[15:0]}
                  + {2'b0, cfg.dst_ip[31:16]} + {2'b0, cfg.dst_ip[15:0]};
  assign ip_fold  = ip_sum2[15:0] + {15'b0, ip_sum2[16]};
  assign tcp_fold = tcp_sum2[15:0] + {15'b0, tcp_sum2[16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      port1    <= in_port;
      ip_sum1  <= IP_CONST_SUM + {1'b0, addr_sum};
      tcp_sum1 <= TCP_CONST_SUM + {1'b0, addr_sum} + {3'b0, in_port};
    end
    if (rdy2) begin
      port2    <= port1;
      ip_sum2  <= {1'b0, ip_sum1[15:0]} + {14'b0, ip_sum1[18:16]};
      tcp_sum2 <= {1'b0, tcp_sum1[15:0]} + {14'b0, tcp_sum1[18:16]};
    end
    if (rdy3) begin
      out_hdr.port      <= port2;
      out_hdr.ip_cksum  <= ~ip_fold;
      out_hdr.tcp_cksum <= ~tcp_fold;
    end
  end

  assign out_valid = v3;

endmodule

// ----- sv/tsfg_serial.sv -----
// ----------------------------------------------------------------------------
// Frame serialiser
// Holds one finished header set and sends its frame one byte per cycle while the frame sink is ready.
// ----------------------------------------------------------------------------
module tsfg_serial
  import tsfg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  hdr_t  in_hdr,
  tsfg_frame_if.source frame
);

  logic             busy;
  logic [IDX_W-1:0] count;
  hdr_t             hdr;
  logic             last;
  logic             out_take;
  logic [7:0]       b;

  assign last     = (count == LAST_IDX);
  assign out_take = frame.valid && frame.ready;
  assign in_ready = !busy || (out_take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (in_valid && in_ready) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (out_take) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        count <= count + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hdr <= in_hdr;
  end

  always_comb begin
    case (count)
      6'd0:  b = cfg.dst_mac[47:40];
      6'd1:  b = cfg.dst_mac[39:32];
      6'd2:  b = cfg.dst_mac[31:24];
      6'd3:  b = cfg.dst_mac[23:16];
      6'd4:  b = cfg.dst_mac[15:8];
      6'd5:  b = cfg.dst_mac[7:0];
      6'd6:  b = cfg.src_mac[47:40];
      6'd7:  b = cfg.src_mac[39:32];
      6'd8:  b = cfg.src_mac[31:24];
      6'd9:  b = cfg.src_mac[23:16];
      6'd10: b = cfg.src_mac[15:8];
      6'd11: b = cfg.src_mac[7:0];
      6'd12: b = ETH_TYPE_IPV4[15:8];
      6'd13: b = ETH_TYPE_IPV4[7:0];
      6'd14: b = IP_VER_IHL;
      6'd16: b = IP_TOTAL_LEN[15:8];
      6'd17: b = IP_TOTAL_LEN[7:0];
      6'd18: b = IP_ID[15:8];
      6'd19: b = IP_ID[7:0];
      6'd22: b = IP_TTL;
      6'd23: b = IP_PROTO_TCP;
      6'd24: b = hdr.ip_cksum[15:8];
      6'd25: b = hdr.ip_cksum[7:0];
      6'd26: b = cfg.src_ip[31:24];
      6'd27: b = cfg.src_ip[23:16];
      6'd28: b = cfg.src_ip[15:8];
      6'd29: b = cfg.src_ip[7:0];
      6'd30: b = cfg.dst_ip[31:24];
      6'd31: b = cfg.dst_ip[23:16];
      6'd32: b = cfg.dst_ip[15:8];
      6'd33: b = cfg.dst_ip[7:0];
      6'd34: b = TCP_SRC_PORT[15:8];
      6'd35: b = TCP_SRC_PORT[7:0];
      6'd36: b = hdr.port[15:8];
      6'd37: b = hdr.port[7:0];
      6'd46: b = TCP_DATA_OFF;
      6'd47: b = TCP_FLAG_SYN;
      6'd48: b = TCP_WINDOW[15:8];
      6'd49: b = TCP_WINDOW[7:0];
      6'd50: b = hdr.tcp_cksum[15:8];
      6'd51: b = hdr.tcp_cksum[7:0];
      6'd54: b = OPT_KIND_MSS;
      6'd55: b = OPT_LEN_MSS;
      6'd56: b = OPT_MSS[15:8];
      6'd57: b = OPT_MSS[7:0];
      default: b = 8'h00;
    endcase
  end

  assign frame.valid      = busy;
  assign frame.frame_byte = b;
  assign frame.byte_index = count;
  assign frame.last_byte  = last;

endmodule

// ----- sv/tcp_syn_frame_generator.sv -----
// ----------------------------------------------------------------------------
// TCP SYN frame generator
// Builds one 58-byte Ethernet II, IPv4 and TCP SYN frame per requested port.
// ----------------------------------------------------------------------------
// Each request item on req carries a TCP destination port and yields one
// 58-byte frame on frame, one byte per item in network order with its offset
// and a last marker on offset 57. The checksums are formed in a three-stage
// pipeline, and the result then passes into the serialiser's header register
// before the first byte appears; the byte output then sets the request rate,
// and a following request is taken while the previous frame is still sent.
// Addresses are written through the APB port at byte addresses 0, 8, 16 and
// 24 (source MAC, destination MAC, source IP, destination IP) and should only
// change while no frame is in progress.
module tcp_syn_frame_generator
  import tsfg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  tsfg_req_if.sink           req,
  tsfg_frame_if.source       frame
);

  cfg_t cfg;
  hdr_t hdr;
  logic hdr_valid;
  logic hdr_ready;

  tsfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsfg_cksum u_cksum (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_port   (req.target_port),
    .out_valid (hdr_valid),
    .out_ready (hdr_ready),
    .out_hdr   (hdr)
  );

  tsfg_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (hdr_valid),
    .in_ready (hdr_ready),
    .in_hdr   (hdr),
    .frame    (frame)
  );

endmodule
